FILE: rtl/asc_pkg.sv
// Shared constants and operation codes for the activity span coalescer.
package asc_pkg;

	// Operation codes carried by one input transaction.
	typedef enum logic [1:0] {
		OP_CHANGE = 2'd0,
		OP_DRAIN  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic CFG_MIN_DURATION = 1'b0;
	localparam logic CFG_MERGE_GAP    = 1'b1;

	// Configuration register width and reset values.
	localparam int CFG_BITS = 16;
	localparam logic [CFG_BITS-1:0] MIN_DURATION_RESET = 16'd1000;
	localparam logic [CFG_BITS-1:0] MERGE_GAP_RESET    = 16'd2000;

	// Default payload widths.
	localparam int KEY_BITS_DEFAULT  = 32;
	localparam int TIME_BITS_DEFAULT = 48;

	// Depth of the result queue between the span logic and the output port.
	localparam int OUT_DEPTH = 4;

endpackage

FILE: rtl/activity_span_coalescer.sv
// Top level of the activity span coalescer: span tracking and result queue.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  operation, activity_key, time_ms
// output    out        out_valid/out_stall  record_valid, span_key, span_start_ms,
//                                           span_end_ms, end_of_drain
// config    in         cfg_write            cfg_index, cfg_data
//
// An input transaction is registered, then processed against the open and held
// spans; one new transaction is taken every cycle while in_stall is low.
// Processing writes zero, one or two results into a four-entry result queue and
// waits only while the queue has fewer than two free entries.
// Results leave in order from the queue head, one per cycle while not stalled.
// Reset clears the spans, the queue and the registers to their reset values.
module activity_span_coalescer
	import asc_pkg::*;
#(
	parameter int KEY_BITS  = KEY_BITS_DEFAULT,
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration port.
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [KEY_BITS-1:0]  activity_key,
	input  logic [TIME_BITS-1:0] time_ms,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 record_valid,
	output logic [KEY_BITS-1:0]  span_key,
	output logic [TIME_BITS-1:0] span_start_ms,
	output logic [TIME_BITS-1:0] span_end_ms,
	output logic                 end_of_drain
);

	localparam int PTR_BITS = $clog2(OUT_DEPTH);
	localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(OUT_DEPTH);
	localparam logic [CNT_BITS-1:0] ROOM_NEED = CNT_BITS'(2);

	// Configuration registers.
	logic [CFG_BITS-1:0] min_duration_q;
	logic [CFG_BITS-1:0] merge_gap_q;

	// Registered input transaction.
	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [TIME_BITS-1:0] time_s1;

	// Span state.
	logic                 open_valid_q;
	logic [KEY_BITS-1:0]  open_key_q;
	logic [TIME_BITS-1:0] open_start_q;
	logic                 held_valid_q;
	logic [KEY_BITS-1:0]  held_key_q;
	logic [TIME_BITS-1:0] held_start_q;
	logic [TIME_BITS-1:0] held_end_q;

	// Result queue.
	logic                 rq_valid_q [OUT_DEPTH];
	logic [KEY_BITS-1:0]  rq_key_q   [OUT_DEPTH];
	logic [TIME_BITS-1:0] rq_start_q [OUT_DEPTH];
	logic [TIME_BITS-1:0] rq_end_q   [OUT_DEPTH];
	logic                 rq_last_q  [OUT_DEPTH];
	logic [PTR_BITS-1:0]  rq_head_q;
	logic [PTR_BITS-1:0]  rq_tail_q;
	logic [CNT_BITS-1:0]  rq_count_q;

	logic                 fire;
	logic                 in_accept;
	logic                 pop;
	logic                 is_change;
	logic                 is_drain;
	logic                 is_clear;
	logic                 closing;
	logic [TIME_BITS:0]   dur_diff;
	logic                 dur_ok;
	logic [TIME_BITS-1:0] gap_diff;
	logic                 merge;
	logic                 span_kept;
	logic                 emit_held;
	logic                 post_held_valid;
	logic [KEY_BITS-1:0]  post_held_key;
	logic [TIME_BITS-1:0] post_held_start;
	logic [TIME_BITS-1:0] post_held_end;
	logic [PTR_BITS-1:0]  drain_slot;
	logic [CNT_BITS-1:0]  push_count;

	// Handshakes.
	assign fire      = valid_s1 && ((DEPTH_CNT - rq_count_q) >= ROOM_NEED);
	assign in_stall  = valid_s1 && !fire;
	assign in_accept = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// Decode of the registered operation.
	assign is_change = (op_s1 == OP_CHANGE) && !(open_valid_q && (open_key_q == key_s1));
	assign is_drain  = (op_s1 == OP_DRAIN);
	assign is_clear  = (op_s1 == OP_CLEAR);
	assign closing   = (is_change || is_drain) && open_valid_q;

	// Duration check of the span being closed; a negative duration fails.
	assign dur_diff = {1'b0, time_s1} - {1'b0, open_start_q};
	assign dur_ok   = !dur_diff[TIME_BITS]
		&& (dur_diff[TIME_BITS-1:0] >= {{(TIME_BITS-CFG_BITS){1'b0}}, min_duration_q});

	// Merge check against the held span; an overlap counts as a negative gap.
	assign gap_diff = open_start_q - held_end_q;
	assign merge    = held_valid_q && (held_key_q == open_key_q)
		&& ((open_start_q <= held_end_q)
		|| (gap_diff <= {{(TIME_BITS-CFG_BITS){1'b0}}, merge_gap_q}));

	assign span_kept = closing && dur_ok;
	assign emit_held = span_kept && !merge && held_valid_q;

	// Held span after the open span has been closed.
	always_comb begin
		post_held_valid = held_valid_q;
		post_held_key   = held_key_q;
		post_held_start = held_start_q;
		post_held_end   = held_end_q;
		if (span_kept) begin
			post_held_end = time_s1;
			if (!merge) begin
				post_held_valid = 1'b1;
				post_held_key   = open_key_q;
				post_held_start = open_start_q;
			end
		end
	end

	assign drain_slot = emit_held ? (rq_tail_q + PTR_BITS'(1)) : rq_tail_q;
	assign push_count = CNT_BITS'(emit_held) + CNT_BITS'(is_drain);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duration_q <= MIN_DURATION_RESET;
			merge_gap_q    <= MERGE_GAP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MIN_DURATION: min_duration_q <= cfg_data;
				CFG_MERGE_GAP:    merge_gap_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Input register: it empties when the held transaction is processed and
	// nothing new arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1   <= operation;
			key_s1  <= activity_key;
			time_s1 <= time_ms;
		end
	end

	// Open and held span update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_valid_q <= 1'b0;
			open_key_q   <= '0;
			open_start_q <= '0;
			held_valid_q <= 1'b0;
			held_key_q   <= '0;
			held_start_q <= '0;
			held_end_q   <= '0;
		end else if (fire) begin
			if (is_clear) begin
				open_valid_q <= 1'b0;
				open_key_q   <= '0;
				open_start_q <= '0;
				held_valid_q <= 1'b0;
				held_key_q   <= '0;
				held_start_q <= '0;
				held_end_q   <= '0;
			end else if (is_drain) begin
				if (open_valid_q) begin
					open_start_q <= time_s1;
				end
				held_valid_q <= 1'b0;
				held_key_q   <= '0;
				held_start_q <= '0;
				held_end_q   <= '0;
			end else if (is_change) begin
				open_valid_q <= 1'b1;
				open_key_q   <= key_s1;
				open_start_q <= time_s1;
				held_valid_q <= post_held_valid;
				held_key_q   <= post_held_key;
				held_start_q <= post_held_start;
				held_end_q   <= post_held_end;
			end
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_head_q  <= '0;
			rq_tail_q  <= '0;
			rq_count_q <= '0;
		end else begin
			if (pop) begin
				rq_head_q <= rq_head_q + PTR_BITS'(1);
			end
			if (fire) begin
				rq_tail_q <= rq_tail_q + PTR_BITS'(push_count);
			end
			rq_count_q <= rq_count_q + (fire ? push_count : '0) - CNT_BITS'(pop);
		end
	end

	// Result queue entries: the emitted held span first, then the drain record.
	always_ff @(posedge clk) begin
		if (fire && emit_held) begin
			rq_valid_q[rq_tail_q] <= 1'b1;
			rq_key_q[rq_tail_q]   <= held_key_q;
			rq_start_q[rq_tail_q] <= held_start_q;
			rq_end_q[rq_tail_q]   <= held_end_q;
			rq_last_q[rq_tail_q]  <= 1'b0;
		end
		if (fire && is_drain) begin
			rq_valid_q[drain_slot] <= post_held_valid;
			rq_key_q[drain_slot]   <= post_held_valid ? post_held_key : '0;
			rq_start_q[drain_slot] <= post_held_valid ? post_held_start : '0;
			rq_end_q[drain_slot]   <= post_held_valid ? post_held_end : '0;
			rq_last_q[drain_slot]  <= 1'b1;
		end
	end

	// Output port from the queue head.
	assign out_valid     = (rq_count_q != '0);
	assign record_valid  = rq_valid_q[rq_head_q];
	assign span_key      = rq_key_q[rq_head_q];
	assign span_start_ms = rq_start_q[rq_head_q];
	assign span_end_ms   = rq_end_q[rq_head_q];
	assign end_of_drain  = rq_last_q[rq_head_q];

	// The queue never holds more entries than it has.
	assert property (@(posedge clk) disable iff (!arst_n) rq_count_q <= DEPTH_CNT)
		else $error("result queue overflow");

	// A transaction is only processed when at least two queue entries are free.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (rq_count_q <= (DEPTH_CNT - ROOM_NEED)))
		else $error("processing without room in the result queue");

	// An empty record only ever ends a drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !record_valid) |-> end_of_drain)
		else $error("empty record outside a drain");

	// A drain always adds its closing record to the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_drain && !pop) |=> (rq_count_q > $past(rq_count_q)))
		else $error("drain without a closing record");

endmodule

FILE: bench/asc_span_checker.sv
// Checker for the activity span coalescer: watches both channels, predicts the spans and compares.
module asc_span_checker
	import asc_pkg::*;
#(
	parameter int KEY_W  = KEY_BITS_DEFAULT,
	parameter int TIME_W = TIME_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [KEY_W-1:0]  activity_key,
	input  logic [TIME_W-1:0] time_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              record_valid,
	input  logic [KEY_W-1:0]  span_key,
	input  logic [TIME_W-1:0] span_start_ms,
	input  logic [TIME_W-1:0] span_end_ms,
	input  logic              end_of_drain,
	output int                fail_count,
	output int                spans_waiting,
	output int                spans_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 40;

	typedef struct {
		logic              rec_valid;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] start_ms;
		logic [TIME_W-1:0] stop_ms;
		logic              drain_end;
	} span_rec_t;

	// Spans predicted but not yet seen on the output channel, oldest first.
	span_rec_t expected_spans[$];

	// Predictor copy of the registers and of the running and kept-back spans.
	logic [CFG_BITS-1:0] min_len;
	logic [CFG_BITS-1:0] join_gap;
	logic                live_valid;
	logic [KEY_W-1:0]    live_key;
	logic [TIME_W-1:0]   live_start;
	logic                kept_valid;
	logic [KEY_W-1:0]    kept_key;
	logic [TIME_W-1:0]   kept_start;
	logic [TIME_W-1:0]   kept_end;

	initial begin
		fail_count = 0;
		spans_waiting = 0;
		spans_checked = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP) begin
			$display("[%0t] span check error: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic queue_span(input logic v, input logic [KEY_W-1:0] k,
			input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e, input logic last);
		span_rec_t r;
		r.rec_valid = v;
		r.key       = v ? k : '0;
		r.start_ms  = v ? s : '0;
		r.stop_ms   = v ? e : '0;
		r.drain_end = last;
		expected_spans.push_back(r);
	endtask

	task automatic drop_kept();
		kept_valid = 1'b0;
		kept_key   = '0;
		kept_start = '0;
		kept_end   = '0;
	endtask

	// Close the running span at time t: drop it if too short, fold it into the
	// kept span when the key matches and the gap is small, else push the kept
	// span out and keep the new one in its place.
	task automatic close_live_span(input logic [TIME_W-1:0] t);
		logic [KEY_W-1:0]  c_key;
		logic [TIME_W-1:0] c_start;
		logic              joins;
		if (!live_valid) begin
			return;
		end
		live_valid = 1'b0;
		c_key   = live_key;
		c_start = live_start;
		if (t < c_start || (t - c_start) < min_len) begin
			return;
		end
		joins = kept_valid && kept_key == c_key &&
			(c_start <= kept_end || (c_start - kept_end) <= join_gap);
		if (joins) begin
			kept_end = t;
			return;
		end
		if (kept_valid) begin
			queue_span(1'b1, kept_key, kept_start, kept_end, 1'b0);
		end
		kept_valid = 1'b1;
		kept_key   = c_key;
		kept_start = c_start;
		kept_end   = t;
	endtask

	// Work out the spans caused by one accepted input transaction.
	task automatic apply_transaction(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] t);
		logic had_live;
		case (op)
			OP_CHANGE: begin
				if (!(live_valid && live_key == key)) begin
					close_live_span(t);
					live_valid = 1'b1;
					live_key   = key;
					live_start = t;
				end
			end
			OP_DRAIN: begin
				had_live = live_valid;
				close_live_span(t);
				if (had_live) begin
					live_valid = 1'b1;
					live_start = t;
				end
				queue_span(kept_valid, kept_key, kept_start, kept_end, 1'b1);
				drop_kept();
			end
			OP_CLEAR: begin
				live_valid = 1'b0;
				live_key   = '0;
				live_start = '0;
				drop_kept();
			end
			default: begin
				// The unused code leaves everything as it is.
			end
		endcase
	endtask

	// Compare one accepted output transaction against the oldest prediction.
	task automatic check_span();
		span_rec_t w;
		if (expected_spans.size() == 0) begin
			report_mismatch($sformatf("unexpected result key %h start %0d end %0d",
				span_key, span_start_ms, span_end_ms));
			return;
		end
		w = expected_spans.pop_front();
		spans_checked++;
		if (record_valid !== w.rec_valid)
			report_mismatch($sformatf("record_valid %b, expected %b", record_valid, w.rec_valid));
		if (span_key !== w.key)
			report_mismatch($sformatf("span_key %h, expected %h", span_key, w.key));
		if (span_start_ms !== w.start_ms)
			report_mismatch($sformatf("span_start_ms %0d, expected %0d",
				span_start_ms, w.start_ms));
		if (span_end_ms !== w.stop_ms)
			report_mismatch($sformatf("span_end_ms %0d, expected %0d", span_end_ms, w.stop_ms));
		if (end_of_drain !== w.drain_end)
			report_mismatch($sformatf("end_of_drain %b, expected %b", end_of_drain, w.drain_end));
	endtask

	// Sample both channels and the register port on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_spans.delete();
			min_len    = MIN_DURATION_RESET;
			join_gap   = MERGE_GAP_RESET;
			live_valid = 1'b0;
			live_key   = '0;
			live_start = '0;
			drop_kept();
			spans_waiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_span();
			end
			if (cfg_write) begin
				if (cfg_index == CFG_MIN_DURATION) begin
					min_len = cfg_data;
				end else begin
					join_gap = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				apply_transaction(operation, activity_key, time_ms);
			end
			spans_waiting <= expected_spans.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// Top of the activity span coalescer testbench: clock, reset, stimulus and verdict.
module tb_top;
	import asc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_W  = KEY_BITS_DEFAULT;
	localparam int TIME_W = TIME_BITS_DEFAULT;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [KEY_W-1:0] KEY_A = 32'h0000_00a5;
	localparam logic [KEY_W-1:0] KEY_B = 32'h5a5a_0001;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_BLOCKS
	} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          operation = OP_CHANGE;
	logic [KEY_W-1:0]    activity_key = '0;
	logic [TIME_W-1:0]   time_ms = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                record_valid;
	logic [KEY_W-1:0]    span_key;
	logic [TIME_W-1:0]   span_start_ms;
	logic [TIME_W-1:0]   span_end_ms;
	logic                end_of_drain;

	int fail_count;
	int spans_waiting;
	int spans_checked;

	// Stimulus bookkeeping.
	int burst_left = 0;
	int cur_min = MIN_DURATION_RESET;
	int cur_gap = MERGE_GAP_RESET;
	int n_change = 0;
	int n_drain = 0;
	int n_clear = 0;
	int n_ignored = 0;
	int n_settings = 0;

	// Receiver stall pattern state.
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	always #6 clk = ~clk;

	activity_span_coalescer #(
		.KEY_BITS(KEY_W),
		.TIME_BITS(TIME_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.activity_key(activity_key),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_valid(record_valid),
		.span_key(span_key),
		.span_start_ms(span_start_ms),
		.span_end_ms(span_end_ms),
		.end_of_drain(end_of_drain)
	);

	asc_span_checker #(
		.KEY_W(KEY_W),
		.TIME_W(TIME_W)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.activity_key(activity_key),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_valid(record_valid),
		.span_key(span_key),
		.span_start_ms(span_start_ms),
		.span_end_ms(span_end_ms),
		.end_of_drain(end_of_drain),
		.fail_count(fail_count),
		.spans_waiting(spans_waiting),
		.spans_checked(spans_checked)
	);

	// The receiver switches at random between stall modes, including
	// stretches where it never stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:  out_stall <= rx_left[3];
			endcase
		end
	end

	// Present one input transaction and hold it until it is taken; the sender
	// then either carries on with its burst or pauses for a random gap.
	task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] t);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		activity_key <= key;
		time_ms <= t;
		do @(posedge clk); while (in_stall);
		case (op)
			OP_CHANGE: n_change++;
			OP_DRAIN:  n_drain++;
			OP_CLEAR:  n_clear++;
			default:   n_ignored++;
		endcase
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending, wait for every predicted span, then let the block settle.
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (spans_waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle.
	task automatic set_config(input int min_ms, input int gap_ms);
		cfg_write <= 1'b1;
		cfg_index <= CFG_MIN_DURATION;
		cfg_data <= min_ms[CFG_BITS-1:0];
		@(posedge clk);
		cfg_index <= CFG_MERGE_GAP;
		cfg_data <= gap_ms[CFG_BITS-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		cur_min = min_ms;
		cur_gap = gap_ms;
		n_settings++;
	endtask

	// Step time forward by amounts scaled to the current thresholds, with an
	// occasional step backwards or a large jump.
	function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
		int kind;
		kind = $urandom_range(0, 19);
		if (kind == 0)
			return t - $urandom_range(1, 5000);
		else if (kind <= 8)
			return t + $urandom_range(0, cur_min + 50);
		else if (kind <= 15)
			return t + $urandom_range(cur_min, cur_min + cur_gap + 100);
		else
			return t + $urandom_range(0, 1 << 20);
	endfunction

	// Mostly changes among a small set of keys so that spans merge and
	// alternate; drains, clears, unused codes and wild timestamps mixed in.
	task automatic run_random_phase(input int n_items);
		logic [KEY_W-1:0]  pool [4];
		logic [TIME_W-1:0] t_now;
		logic [KEY_W-1:0]  key;
		logic [1:0]        op;
		int                pick;
		int                sent;
		for (int i = 0; i < 4; i++) pool[i] = $urandom;
		if ($urandom_range(0, 2) == 0) begin
			pool[0] = '0;
		end else if ($urandom_range(0, 1) == 0) begin
			pool[0] = '1;
		end
		if ($urandom_range(0, 4) == 0) begin
			t_now = TIME_MAX - $urandom_range(0, 1 << 20);
		end else begin
			t_now = TIME_W'($urandom);
		end
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			key = ($urandom_range(0, 6) == 0) ? KEY_W'($urandom) : pool[$urandom_range(0, 3)];
			t_now = next_time(t_now);
			if (pick < 78) begin
				op = OP_CHANGE;
			end else if (pick < 88) begin
				op = OP_DRAIN;
			end else if (pick < 92) begin
				op = OP_CLEAR;
			end else if (pick < 95) begin
				op = OP_UNUSED;
			end else begin
				op = OP_CHANGE;
				t_now = TIME_W'({$urandom, $urandom});
			end
			send_item(op, key, t_now);
			if (op != OP_UNUSED) begin
				sent++;
			end
		end
	endtask

	// Watchdog for a hung handshake.
	initial begin
		#(5_000_000);
		$display("activity_span_coalescer regression: fail");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sequence at the reset thresholds (1000 ms, 2000 ms).
		send_item(OP_DRAIN, KEY_A, 0);            // drain with nothing kept
		send_item(OP_CHANGE, KEY_A, 0);
		send_item(OP_CHANGE, KEY_A, 10);          // same key as the running span
		send_item(OP_CHANGE, KEY_B, 5000);        // A kept
		send_item(OP_CHANGE, KEY_A, 5500);        // short B dropped
		send_item(OP_CHANGE, KEY_B, 7000);        // A joins the kept A
		send_item(OP_CHANGE, KEY_A, 20000);       // kept A goes out, B kept
		send_item(OP_DRAIN, KEY_A, 21000);        // two results from one drain
		send_item(OP_CHANGE, KEY_B, 100);         // time runs backwards: dropped
		send_item(OP_CHANGE, KEY_A, 200000);      // B kept
		send_item(OP_CHANGE, KEY_B, 150000);      // backwards A dropped
		send_item(OP_CHANGE, KEY_A, 160000);      // B starts before kept end: joins
		send_item(OP_UNUSED, KEY_A, 170000);      // unused code ignored
		send_item(OP_DRAIN, KEY_A, 170000);
		send_item(OP_CLEAR, KEY_B, 0);
		send_item(OP_DRAIN, KEY_B, 180000);       // drain right after a clear
		send_item(OP_CHANGE, KEY_A, 1000);
		send_item(OP_CHANGE, KEY_B, 1999);        // one below the minimum: dropped
		send_item(OP_CHANGE, KEY_A, 2999);        // exactly the minimum: kept
		send_item(OP_CHANGE, KEY_B, 4000);
		send_item(OP_CLEAR, KEY_A, 4000);         // kept span discarded silently
		send_item(OP_CHANGE, '1, 0);
		send_item(OP_CHANGE, '0, TIME_MAX);       // longest possible span
		send_item(OP_DRAIN, '1, TIME_MAX);
		send_item(OP_CLEAR, '0, TIME_MAX);
		finish_phase();

		// Random phases across register settings, extremes included.
		set_config(0, 0);
		run_random_phase(150);
		finish_phase();
		set_config(65535, 65535);
		run_random_phase(150);
		finish_phase();
		set_config(0, 65535);
		run_random_phase(150);
		finish_phase();
		set_config(65535, 0);
		run_random_phase(150);
		finish_phase();
		set_config(MIN_DURATION_RESET, MERGE_GAP_RESET);
		run_random_phase(200);
		finish_phase();
		set_config($urandom_range(0, 65535), $urandom_range(0, 65535));
		run_random_phase(150);
		finish_phase();
		set_config($urandom_range(0, 300), $urandom_range(0, 300));
		run_random_phase(150);
		finish_phase();

		$display("Covered %0d changes, %0d drains, %0d clears, %0d unused codes; %0d results checked.",
			n_change, n_drain, n_clear, n_ignored, spans_checked);
		$display("Ran under %0d register settings, both limits of each register among them.",
			n_settings);
		if (fail_count == 0) begin
			$display("activity_span_coalescer regression: pass");
		end else begin
			$display("activity_span_coalescer regression: fail");
		end
		$finish;
	end

endmodule

FILE: activity_span_coalescer.f
rtl/asc_pkg.sv
rtl/activity_span_coalescer.sv
bench/asc_span_checker.sv
bench/tb_top.sv
